// ===== hdl/eplm_pkg.sv =====
// Shared types and codes for the echo probe link monitor.
package eplm_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_REPLY = 2'd1,
		OP_POLL  = 2'd2,
		OP_CLEAR = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_WAIT       = 2'd0,
		ST_FAILED     = 2'd1,
		ST_SUCCEEDED  = 2'd2,
		ST_NO_NETWORK = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		PH_SEND  = 2'd0,
		PH_AWAIT = 2'd1,
		PH_DELAY = 2'd2
	} phase_e;

	typedef enum logic [1:0] {
		REG_REPLY_TIMEOUT  = 2'd0,
		REG_RETRY_DELAY    = 2'd1,
		REG_SUCCESS_STREAK = 2'd2,
		REG_FAILURE_STREAK = 2'd3
	} reg_index_e;

	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [3:0]  COUNT_MAX  = 4'd15;

	typedef struct packed {
		logic [1:0]  operation;
		logic        link_up;
		logic [31:0] target_address;
	} probe_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        send_request;
		logic [31:0] send_address;
		logic [15:0] reported_latency;
	} report_t;

	typedef struct packed {
		logic [15:0] reply_timeout;
		logic [15:0] retry_delay;
		logic [3:0]  success_streak;
		logic [3:0]  failure_streak;
	} cfg_t;

	// Monitor state apart from the countdown, whose width is a parameter.
	typedef struct packed {
		phase_e      phase;
		logic        expired;
		logic [3:0]  success_count;
		logic [3:0]  failure_count;
		logic        reply_pending;
		logic [15:0] last_latency;
		logic [15:0] max_latency;
	} mon_state_t;

endpackage

// ===== hdl/eplm_cfg.sv =====
// Configuration register file of the echo probe link monitor.
module eplm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [eplm_pkg::CFG_DATA_W-1:0] cfg_data,
	output eplm_pkg::cfg_t                  cfg
);

	eplm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reply_timeout  <= 16'd1000;
			cfg_q.retry_delay    <= 16'd1000;
			cfg_q.success_streak <= 4'd4;
			cfg_q.failure_streak <= 4'd4;
		end else if (cfg_write) begin
			case (eplm_pkg::reg_index_e'(cfg_index))
				eplm_pkg::REG_REPLY_TIMEOUT: begin
					cfg_q.reply_timeout <= cfg_data[15:0];
				end
				eplm_pkg::REG_RETRY_DELAY: begin
					cfg_q.retry_delay <= cfg_data[15:0];
				end
				eplm_pkg::REG_SUCCESS_STREAK: begin
					cfg_q.success_streak <= cfg_data[3:0];
				end
				eplm_pkg::REG_FAILURE_STREAK: begin
					cfg_q.failure_streak <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/eplm_step.sv =====
// Next-state and report logic for one monitor request.
module eplm_step #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  eplm_pkg::cfg_t         cfg,
	input  eplm_pkg::probe_t       probe,
	input  eplm_pkg::mon_state_t   st,
	input  logic [TIMER_BITS-1:0]  countdown,
	output eplm_pkg::mon_state_t   st_nxt,
	output logic [TIMER_BITS-1:0]  countdown_nxt,
	output eplm_pkg::report_t      report
);

	always_comb begin
		eplm_pkg::mon_state_t   s;
		logic [TIMER_BITS-1:0]  cd;
		eplm_pkg::report_t      r;

		s  = st;
		cd = countdown;
		r  = '0;
		r.status = eplm_pkg::ST_WAIT;

		case (eplm_pkg::op_e'(probe.operation))
			eplm_pkg::OP_TICK: begin
				if (cd != '0) begin
					cd = cd - TIMER_BITS'(1);
					if (cd == '0) begin
						s.expired = 1'b1;
					end
				end
			end
			eplm_pkg::OP_REPLY: begin
				s.last_latency  = cfg.reply_timeout - 16'(cd);
				s.reply_pending = 1'b1;
			end
			eplm_pkg::OP_POLL: begin
				if (!probe.link_up) begin
					r.status = eplm_pkg::ST_NO_NETWORK;
				end else begin
					case (s.phase)
						eplm_pkg::PH_SEND: begin
							r.send_request = 1'b1;
							r.send_address = probe.target_address;
							s.phase        = eplm_pkg::PH_AWAIT;
							cd             = TIMER_BITS'(cfg.reply_timeout);
							s.expired      = 1'b0;
						end
						eplm_pkg::PH_AWAIT: begin
							if (s.expired) begin
								cd              = TIMER_BITS'(cfg.retry_delay);
								s.expired       = 1'b0;
								s.phase         = eplm_pkg::PH_DELAY;
								s.success_count = '0;
								if (s.failure_count != eplm_pkg::COUNT_MAX) begin
									s.failure_count = s.failure_count + 4'd1;
								end
								s.max_latency  = '0;
								s.last_latency = '0;
							end
							if (s.reply_pending) begin
								if (s.success_count == '0 ||
								    s.last_latency >= s.max_latency) begin
									s.max_latency = s.last_latency;
								end
								cd              = TIMER_BITS'(cfg.retry_delay);
								s.expired       = 1'b0;
								s.phase         = eplm_pkg::PH_DELAY;
								s.failure_count = '0;
								s.reply_pending = 1'b0;
								if (s.success_count != eplm_pkg::COUNT_MAX) begin
									s.success_count = s.success_count + 4'd1;
								end
							end
						end
						eplm_pkg::PH_DELAY: begin
							if (s.expired) begin
								s.expired = 1'b0;
								s.phase   = eplm_pkg::PH_SEND;
							end
						end
						default: begin
						end
					endcase
					if (s.failure_count >= cfg.failure_streak) begin
						s.failure_count = '0;
						s.success_count = '0;
						r.status        = eplm_pkg::ST_FAILED;
					end
					// success check wins over failure
					if (s.success_count >= cfg.success_streak) begin
						s.failure_count = '0;
						s.success_count = '0;
						r.status        = eplm_pkg::ST_SUCCEEDED;
					end
				end
			end
			eplm_pkg::OP_CLEAR: begin
				s.phase         = eplm_pkg::PH_SEND;
				s.success_count = '0;
				s.failure_count = '0;
				cd              = '0;
				s.expired       = 1'b0;
			end
			default: begin
			end
		endcase

		r.reported_latency = s.max_latency;
		st_nxt        = s;
		countdown_nxt = cd;
		report        = r;
	end

endmodule

// ===== hdl/echo_probe_link_monitor_core.sv =====
// Top level of the echo probe link monitor: state, result register and checks.
//
//  channel  dir  handshake                  payload
//  probe    in   probe_valid / probe_ready  eplm_pkg::probe_t
//  report   out  report_valid / report_ready eplm_pkg::report_t
//  cfg      in   cfg_write                  cfg_index, cfg_data
//
// One request per cycle while probe_ready is high; its report appears in the result
// register the cycle after acceptance.
// State updates in the same edge that accepts the request.
// probe_ready is low only while a report is held and report_ready is low.
// arst_n clears state and configuration to reset values; no clearing pass.
module echo_probe_link_monitor_core #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            probe_valid,
	output logic                            probe_ready,
	input  eplm_pkg::probe_t                probe,
	output logic                            report_valid,
	input  logic                            report_ready,
	output eplm_pkg::report_t               report,
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [eplm_pkg::CFG_DATA_W-1:0] cfg_data
);

	eplm_pkg::cfg_t        cfg;
	eplm_pkg::mon_state_t  st_q;
	eplm_pkg::mon_state_t  st_nxt;
	logic [TIMER_BITS-1:0] countdown_q;
	logic [TIMER_BITS-1:0] countdown_nxt;
	eplm_pkg::report_t     report_nxt;
	eplm_pkg::report_t     report_s1;
	logic                  report_valid_s1;
	logic                  accept;

	eplm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eplm_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.cfg           (cfg),
		.probe         (probe),
		.st            (st_q),
		.countdown     (countdown_q),
		.st_nxt        (st_nxt),
		.countdown_nxt (countdown_nxt),
		.report        (report_nxt)
	);

	assign probe_ready = !report_valid_s1 || report_ready;
	assign accept      = probe_valid && probe_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= eplm_pkg::PH_SEND;
			st_q.expired       <= 1'b0;
			st_q.success_count <= '0;
			st_q.failure_count <= '0;
			st_q.reply_pending <= 1'b0;
			st_q.last_latency  <= '0;
			st_q.max_latency   <= '0;
			countdown_q        <= '0;
		end else if (accept) begin
			st_q        <= st_nxt;
			countdown_q <= countdown_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_s1 <= 1'b0;
		end else if (probe_ready) begin
			report_valid_s1 <= probe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			report_s1 <= report_nxt;
		end
	end

	assign report_valid = report_valid_s1;
	assign report       = report_s1;

`ifndef SYNTHESIS
	a_report_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> report_valid)
		else $error("accepted request gave no report");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!report_valid |-> probe_ready)
		else $error("request stalled with empty result register");

	a_expired_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.expired |-> (countdown_q == '0))
		else $error("expired flag set with timer running");

	a_one_streak: assert property (@(posedge clk) disable iff (!arst_n)
		!((st_q.success_count != '0) && (st_q.failure_count != '0)))
		else $error("success and failure streaks both running");
`endif

endmodule
